// File: rtl/shcg_pkg.sv
// Shared types, codes and direction tables for the seeded hit cluster grower.
package shcg_pkg;

  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int SIZE_W    = 17;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_GROW  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_OUTSIDE  = 3'd1,
    STAT_NEW      = 3'd2,
    STAT_EXISTING = 3'd3,
    STAT_NOTHING  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_CHAN_ORIGIN = 3'd1,
    REG_TICK_ORIGIN = 3'd2,
    REG_SEED_CH_OFS = 3'd3,
    REG_SEED_TK_OFS = 3'd4,
    REG_REACH_CH    = 3'd5,
    REG_REACH_TK    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_NOP,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SIZE_OUT,
    ST_POP_RD,
    ST_NB_RD,
    ST_NB_CHK,
    ST_UNMARK_RD,
    ST_UNMARK_WR
  } state_t;

  // Column step of the k-th probe or neighbor: +,-,0,0,+,-,+,-.
  function automatic dir_t dir_x(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd0, 3'd4, 3'd6: d = DIR_POS;
      3'd1, 3'd5, 3'd7: d = DIR_NEG;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

  // Row step of the k-th probe or neighbor: 0,0,+,-,+,+,-,-.
  function automatic dir_t dir_y(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd2, 3'd4, 3'd5: d = DIR_POS;
      3'd3, 3'd6, 3'd7: d = DIR_NEG;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

  function automatic logic signed [COORD_W-1:0] step(input dir_t d,
                                                     input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    case (d)
      DIR_POS: r = v;
      DIR_NEG: r = -v;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/seeded_hit_cluster_grower_core.sv
// Seeded hit cluster grower: occupancy grid, nearest-bin search and 8-connected flood fill.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  item in | in        | start, busy          | command channel tick signal cluster_index
//  result  | out       | done (one-cycle pulse) | status cluster_id cluster_size seed_column seed_row
//  config  | in        | cfg_write            | cfg_index cfg_data
//
//  After reset the grid is swept clear, one bin a cycle (2^(CW+RW) bins, 65536 by
//  default) with busy high. Clear runs the same sweep; load and an undefined command
//  finish in a single state. A grow reads and then checks each in-grid probe and only
//  reads a probe off the grid (seed plus up to 8*reach_channel*reach_tick); an
//  existing cluster adds a size read. A fill takes per bin one queue read and a read
//  and a check per in-grid neighbor (only a read per neighbor off the grid), one step
//  to find the queue empty, then a read and a write per bin to drop its visit mark;
//  the single grid port makes these steps serial. The result appears in the cycle after
//  the last step and cannot be held off; busy is low in it, so the next item may start.
module seeded_hit_cluster_grower_core #(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 256,
  parameter int MAX_CLUSTERS = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [12:0]                     channel,
  input  logic [12:0]                     tick,
  input  logic signed [15:0]              signal,
  input  logic [7:0]                      cluster_index,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [7:0]                      cluster_id,
  output logic [shcg_pkg::SIZE_W-1:0]     cluster_size,
  output logic [7:0]                      seed_column,
  output logic [7:0]                      seed_row,
  input  logic                            cfg_write,
  input  logic [shcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shcg_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import shcg_pkg::*;

  localparam int CW    = $clog2(GRID_COLUMNS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int AW    = CW + RW;
  localparam int CELLS = 1 << AW;
  localparam int IDW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  // Configuration
  logic signed [15:0] thr;
  logic [12:0]        ch_org, tk_org;
  logic signed [12:0] ch_ofs, tk_ofs;
  logic [3:0]         reach_c, reach_t;

  // Memories
  logic              occ_mem [CELLS];
  logic [7:0]        lab_mem [CELLS];
  logic              vis_mem [CELLS];
  logic [AW-1:0]     q_mem   [CELLS];
  logic [SIZE_W-1:0] size_mem[MAX_CLUSTERS];

  logic              occ_q, vis_q;
  logic [7:0]        lab_q;
  logic [AW-1:0]     q_q;
  logic [SIZE_W-1:0] size_q;

  // Sequencer registers
  state_t                    state, state_next;
  logic [AW-1:0]             sweep, sweep_next;
  logic signed [COORD_W-1:0] base_c, base_c_next, base_r, base_r_next;
  logic signed [COORD_W-1:0] p_c, p_c_next, p_r, p_r_next;
  logic                      hit_ok, hit_ok_next;
  logic [7:0]                id_r, id_r_next;
  logic                      srch, srch_next;
  logic [3:0]                dx, dx_next, dy, dy_next;
  logic [2:0]                k, k_next;
  logic [AW:0]               head, head_next, tail, tail_next;
  logic [SIZE_W-1:0]         res_size, res_size_next;
  logic [7:0]                res_col, res_col_next, res_row, res_row_next;

  // Control
  logic              occ_we, lab_we, vis_we, occ_wd, vis_wd, q_we, q_re, sz_we, sz_re;
  logic [7:0]        lab_wd;
  logic [AW-1:0]     gaddr;
  logic [IDW-1:0]    sz_raddr;
  logic              fin, adv, nadv;
  status_t           fin_status;
  logic [7:0]        fin_id, fin_col, fin_row, lab_id;
  logic [SIZE_W-1:0] fin_size, tail_sz;

  logic signed [COORD_W-1:0] pc, pr, nc, nr, qc, qr, pdx, pdy, gr_c, gr_r, ld_c, ld_r;
  logic signed [COORD_W-1:0] one;

  function automatic logic in_grid(input logic signed [COORD_W-1:0] c,
                                   input logic signed [COORD_W-1:0] r);
    return !c[COORD_W-1] && (c < COORD_W'(GRID_COLUMNS))
        && !r[COORD_W-1] && (r < COORD_W'(GRID_ROWS));
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [COORD_W-1:0] c,
                                              input logic signed [COORD_W-1:0] r);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  function automatic logic [7:0] sat_id(input logic [7:0] v);
    return (v >= 8'(MAX_CLUSTERS)) ? 8'(MAX_CLUSTERS - 1) : v;
  endfunction

  assign one     = COORD_W'(1);
  assign pdx     = srch ? COORD_W'(dx) : '0;
  assign pdy     = srch ? COORD_W'(dy) : '0;
  assign pc      = base_c + step(dir_x(k), pdx);
  assign pr      = base_r + step(dir_y(k), pdy);
  assign qc      = COORD_W'(q_q[CW-1:0]);
  assign qr      = COORD_W'(q_q[AW-1:CW]);
  assign nc      = qc + step(dir_x(k), one);
  assign nr      = qr + step(dir_y(k), one);
  assign ld_c    = COORD_W'(channel) - COORD_W'(ch_org);
  assign ld_r    = COORD_W'(tick) - COORD_W'(tk_org);
  assign gr_c    = ld_c - COORD_W'(ch_ofs);
  assign gr_r    = ld_r - COORD_W'(tk_ofs);
  assign tail_sz = SIZE_W'(tail);
  assign lab_id  = sat_id(lab_q - 8'd1);
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0; ch_org <= '0; tk_org <= '0; ch_ofs <= '0; tk_ofs <= '0;
      reach_c <= '0; reach_t <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:   thr     <= signed'(cfg_data);
        REG_CHAN_ORIGIN: ch_org  <= cfg_data[12:0];
        REG_TICK_ORIGIN: tk_org  <= cfg_data[12:0];
        REG_SEED_CH_OFS: ch_ofs  <= signed'(cfg_data[12:0]);
        REG_SEED_TK_OFS: tk_ofs  <= signed'(cfg_data[12:0]);
        REG_REACH_CH:    reach_c <= cfg_data[3:0];
        REG_REACH_TK:    reach_t <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[gaddr] <= occ_wd;
    if (lab_we) lab_mem[gaddr] <= lab_wd;
    if (vis_we) vis_mem[gaddr] <= vis_wd;
    occ_q <= occ_mem[gaddr];
    lab_q <= lab_mem[gaddr];
    vis_q <= vis_mem[gaddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail[AW-1:0]] <= gaddr;
    if (q_re) q_q <= q_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sz_we) size_mem[id_r[IDW-1:0]] <= tail_sz;
    if (sz_re) size_q <= size_mem[sz_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      head  <= '0;
      tail  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      head  <= head_next;
      tail  <= tail_next;
      done  <= fin;
    end
    base_c <= base_c_next;  base_r <= base_r_next;
    p_c <= p_c_next;        p_r <= p_r_next;
    hit_ok <= hit_ok_next;  id_r <= id_r_next;
    srch <= srch_next;      dx <= dx_next;  dy <= dy_next;  k <= k_next;
    res_size <= res_size_next;
    res_col <= res_col_next; res_row <= res_row_next;
    status <= fin_status;   cluster_id <= fin_id;  cluster_size <= fin_size;
    seed_column <= fin_col; seed_row <= fin_row;
  end

  always_comb begin
    state_next = state;       sweep_next = sweep;
    base_c_next = base_c;     base_r_next = base_r;
    p_c_next = p_c;           p_r_next = p_r;
    hit_ok_next = hit_ok;     id_r_next = id_r;
    srch_next = srch;         dx_next = dx;  dy_next = dy;  k_next = k;
    head_next = head;         tail_next = tail;
    res_size_next = res_size; res_col_next = res_col;  res_row_next = res_row;
    occ_we = 1'b0; lab_we = 1'b0; vis_we = 1'b0;
    occ_wd = 1'b0; lab_wd = '0;   vis_wd = 1'b0;
    q_we = 1'b0; q_re = 1'b0; sz_we = 1'b0; sz_re = 1'b0;
    sz_raddr = lab_id[IDW-1:0];
    gaddr = sweep;
    fin = 1'b0; fin_status = STAT_DONE;
    fin_id = '0; fin_size = '0; fin_col = '0; fin_row = '0;
    adv = 1'b0; nadv = 1'b0;

    case (state)
      ST_INIT, ST_CLEAR: begin
        occ_we = 1'b1; lab_we = 1'b1; vis_we = 1'b1;
        sweep_next = sweep + 1'b1;
        if (&sweep) begin
          fin = (state == ST_CLEAR);
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(command))
            CMD_CLEAR: begin
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            CMD_LOAD: begin
              base_c_next = ld_c;
              base_r_next = ld_r;
              hit_ok_next = (signal > thr);
              state_next  = ST_LOAD;
            end
            CMD_GROW: begin
              base_c_next = gr_c;
              base_r_next = gr_r;
              id_r_next   = sat_id(cluster_index);
              srch_next   = 1'b0;
              k_next      = '0;
              head_next   = '0;
              tail_next   = '0;
              state_next  = ST_PROBE_RD;
            end
            default: state_next = ST_NOP;
          endcase
        end
      end
      ST_NOP: begin
        fin = 1'b1;
        state_next = ST_IDLE;
      end
      ST_LOAD: begin
        gaddr = cell_addr(base_c, base_r);
        fin = 1'b1;
        if (!in_grid(base_c, base_r)) begin
          fin_status = STAT_OUTSIDE;
        end else begin
          occ_we = hit_ok;
          occ_wd = 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_PROBE_RD: begin
        gaddr = cell_addr(pc, pr);
        p_c_next = pc;
        p_r_next = pr;
        if (in_grid(pc, pr)) state_next = ST_PROBE_CHK;
        else adv = 1'b1;
      end
      ST_PROBE_CHK: begin
        gaddr = cell_addr(p_c, p_r);
        if (occ_q) begin
          res_col_next = p_c[7:0];
          res_row_next = p_r[7:0];
          if (lab_q != 8'd0) begin
            sz_re = 1'b1;
            id_r_next = lab_id;
            state_next = ST_SIZE_OUT;
          end else begin
            // Seed bin starts the fill: mark, label and enqueue it at slot zero.
            vis_we = 1'b1; vis_wd = 1'b1;
            lab_we = 1'b1; lab_wd = id_r + 8'd1;
            q_we = 1'b1;
            tail_next = (AW+1)'(1);
            state_next = ST_POP_RD;
          end
        end else begin
          adv = 1'b1;
        end
      end
      ST_SIZE_OUT: begin
        fin = 1'b1;
        fin_status = STAT_EXISTING;
        fin_id = id_r; fin_size = size_q; fin_col = res_col; fin_row = res_row;
        state_next = ST_IDLE;
      end
      ST_POP_RD: begin
        if (head == tail) begin
          sz_we = 1'b1;
          res_size_next = tail_sz;
          head_next = '0;
          state_next = ST_UNMARK_RD;
        end else begin
          q_re = 1'b1;
          head_next = head + 1'b1;
          k_next = '0;
          state_next = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        gaddr = cell_addr(nc, nr);
        if (in_grid(nc, nr)) state_next = ST_NB_CHK;
        else nadv = 1'b1;
      end
      ST_NB_CHK: begin
        gaddr = cell_addr(nc, nr);
        if (occ_q && !vis_q) begin
          vis_we = 1'b1; vis_wd = 1'b1;
          lab_we = 1'b1; lab_wd = id_r + 8'd1;
          q_we = 1'b1;
          tail_next = tail + 1'b1;
        end
        nadv = 1'b1;
      end
      ST_UNMARK_RD: begin
        q_re = 1'b1;
        state_next = ST_UNMARK_WR;
      end
      ST_UNMARK_WR: begin
        gaddr = q_q;
        vis_we = 1'b1;
        head_next = head + 1'b1;
        if (head + 1'b1 == tail) begin
          fin = 1'b1;
          fin_status = STAT_NEW;
          fin_id = id_r; fin_size = res_size; fin_col = res_col; fin_row = res_row;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_UNMARK_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Step to the next probe in search order, or give up.
    if (adv) begin
      state_next = ST_PROBE_RD;
      if (!srch) begin
        if (reach_c == 4'd0 || reach_t == 4'd0) begin
          fin = 1'b1;
          fin_status = STAT_NOTHING;
          state_next = ST_IDLE;
        end else begin
          srch_next = 1'b1; dx_next = 4'd1; dy_next = 4'd1; k_next = '0;
        end
      end else if (k != 3'd7) begin
        k_next = k + 1'b1;
      end else begin
        k_next = '0;
        if (dy != reach_t) begin
          dy_next = dy + 1'b1;
        end else begin
          dy_next = 4'd1;
          if (dx != reach_c) begin
            dx_next = dx + 1'b1;
          end else begin
            fin = 1'b1;
            fin_status = STAT_NOTHING;
            state_next = ST_IDLE;
          end
        end
      end
    end

    if (nadv) begin
      if (k == 3'd7) begin
        state_next = ST_POP_RD;
      end else begin
        k_next = k + 1'b1;
        state_next = ST_NB_RD;
      end
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("frontier read pointer passed write pointer");
  a_nothing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_NOTHING) |-> (cluster_id == 8'd0 && cluster_size == '0))
    else $error("nothing-found result carries a cluster");

endmodule

// File: tb/seeded_hit_cluster_grower_core_tb.sv
// Self-checking testbench for the seeded hit cluster grower core.
module seeded_hit_cluster_grower_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shcg_pkg::*;

  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int NBINS = 256 * 256;
  localparam int WIN   = 16;
  localparam int PDX[8] = '{1, -1, 0, 0, 1, -1, 1, -1};
  localparam int PDY[8] = '{0, 0, 1, -1, 1, 1, -1, -1};

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  id;
    logic [16:0] size;
    logic [7:0]  col;
    logic [7:0]  row;
  } grow_res_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    ridx;
    logic [15:0] val;
    logic [1:0]  cmd;
    logic [12:0] ch;
    logic [12:0] tk;
    logic [15:0] sg;
    logic [7:0]  ix;
    bit          typed;
    grow_res_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = '0;
  logic [12:0] channel = '0;
  logic [12:0] tick = '0;
  logic signed [15:0] signal = '0;
  logic [7:0] cluster_index = '0;
  logic done;
  logic [2:0] status;
  logic [7:0] cluster_id;
  logic [SIZE_W-1:0] cluster_size;
  logic [7:0] seed_column;
  logic [7:0] seed_row;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  seeded_hit_cluster_grower_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .channel(channel), .tick(tick), .signal(signal),
    .cluster_index(cluster_index), .done(done), .status(status),
    .cluster_id(cluster_id), .cluster_size(cluster_size),
    .seed_column(seed_column), .seed_row(seed_row),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the block's state.
  int thr, corg, torg, sco, sto, reach_ch, reach_tk;
  bit occ[NBINS];
  bit visited[NBINS];
  logic [7:0] lbl[NBINS];
  logic [16:0] csize[255];

  grow_res_t pending_results[$];
  stim_row_t rows[$];
  int fails = 0;

  function automatic void add_row(stim_row_t row);
    rows = {rows, row};
  endfunction

  function automatic bit occ_at(int c, int r);
    if (c < 0 || c > 255 || r < 0 || r > 255) return 1'b0;
    return occ[r * 256 + c];
  endfunction

  function automatic grow_res_t cluster_outcome(logic [1:0] cmd, logic [12:0] ch,
                                                logic [12:0] tk, logic signed [15:0] sg,
                                                logic [7:0] ix);
    grow_res_t r;
    int c, rw, dx, dy, k, id, head, cur, nc, nr, n;
    bit found;
    int fq[$];
    r = '0;
    r.status = STAT_DONE;
    case (cmd)
      CMD_CLEAR: begin
        for (n = 0; n < NBINS; n++) begin
          occ[n] = 1'b0;
          lbl[n] = '0;
        end
      end
      CMD_LOAD: begin
        c = int'(ch) - corg;
        rw = int'(tk) - torg;
        if (c < 0 || c > 255 || rw < 0 || rw > 255) r.status = STAT_OUTSIDE;
        else if (int'(sg) > thr) occ[rw * 256 + c] = 1'b1;
      end
      CMD_GROW: begin
        c = int'(ch) - sco - corg;
        rw = int'(tk) - sto - torg;
        found = occ_at(c, rw);
        for (dx = 1; dx <= reach_ch && !found; dx++)
          for (dy = 1; dy <= reach_tk && !found; dy++)
            for (k = 0; k < 8 && !found; k++)
              if (occ_at(c + PDX[k] * dx, rw + PDY[k] * dy)) begin
                found = 1'b1;
                c = c + PDX[k] * dx;
                rw = rw + PDY[k] * dy;
              end
        if (!found) begin
          r.status = STAT_NOTHING;
        end else begin
          r.col = c[7:0];
          r.row = rw[7:0];
          if (lbl[rw * 256 + c] != 0) begin
            r.status = STAT_EXISTING;
            id = int'(lbl[rw * 256 + c]) - 1;
            if (id > 254) id = 254;
            r.id = id[7:0];
            r.size = csize[id];
          end else begin
            r.status = STAT_NEW;
            id = (int'(ix) > 254) ? 254 : int'(ix);
            r.id = id[7:0];
            // Breadth-first fill; visit marks are dropped afterwards.
            fq = {fq, rw * 256 + c};
            visited[rw * 256 + c] = 1'b1;
            lbl[rw * 256 + c] = 8'(id + 1);
            head = 0;
            while (head < fq.size()) begin
              cur = fq[head];
              head++;
              for (k = 0; k < 8; k++) begin
                nc = cur % 256 + PDX[k];
                nr = cur / 256 + PDY[k];
                if (occ_at(nc, nr) && !visited[nr * 256 + nc]) begin
                  visited[nr * 256 + nc] = 1'b1;
                  lbl[nr * 256 + nc] = 8'(id + 1);
                  fq = {fq, nr * 256 + nc};
                end
              end
            end
            foreach (fq[n]) visited[fq[n]] = 1'b0;
            r.size = 17'(fq.size());
            csize[id] = r.size;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(logic [1:0] cmd, logic [12:0] ch, logic [12:0] tk,
                           logic [15:0] sg, logic [7:0] ix, bit typed, grow_res_t tres);
    grow_res_t p;
    start <= 1'b1;
    command <= cmd;
    channel <= ch;
    tick <= tk;
    signal <= sg;
    cluster_index <= ix;
    do @(posedge clk); while (busy);
    p = cluster_outcome(cmd, ch, tk, sg, ix);
    pending_results = {pending_results, typed ? tres : p};
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:   thr = int'($signed(val));
      REG_CHAN_ORIGIN: corg = int'(val[12:0]);
      REG_TICK_ORIGIN: torg = int'(val[12:0]);
      REG_SEED_CH_OFS: sco = int'($signed(val[12:0]));
      REG_SEED_TK_OFS: sto = int'($signed(val[12:0]));
      REG_REACH_CH:    reach_ch = int'(val[3:0]);
      REG_REACH_TK:    reach_tk = int'(val[3:0]);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    grow_res_t want, got;
    if (!rst && done) begin
      got = '{status, cluster_id, cluster_size, seed_column, seed_row};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          fails++;
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase_idle[7] = '{0, 78, 11, 30, 0, 78, 50};
    int ph, i, pct, wc, wr, sel, col, row, v;
    logic [15:0] sg;
    thr = 0; corg = 0; torg = 0; sco = 0; sto = 0; reach_ch = 0; reach_tk = 0;
    foreach (csize[i]) csize[i] = '0;
    for (i = 0; i < NBINS; i++) begin
      occ[i] = 1'b0;
      lbl[i] = '0;
      visited[i] = 1'b0;
    end

    // Directed part: grid edges, thresholds, origins, offsets and reach extremes.
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 5, 5, 0, 1, 1,
              '{STAT_NOTHING, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_UNDEF, 13'h1fff, 13'h1fff, 16'hffff, 8'hff, 1,
              '{STAT_DONE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 5, 5, 1, 0, 1,
              '{STAT_DONE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 7, 7, 0, 0, 1,
              '{STAT_DONE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 256, 5, 1, 0, 1,
              '{STAT_OUTSIDE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 5, 13'h1fff, 16'h7fff, 0, 1,
              '{STAT_OUTSIDE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 5, 5, 0, 7, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 5, 5, 0, 9, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 6, 6, 1, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 255, 255, 16'h7fff, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 6, 6, 0, 8'hff, 0, '0});
    add_row('{1, REG_REACH_CH, 15, 0, 0, 0, 0, 0, 0, '0});
    add_row('{1, REG_REACH_TK, 15, 0, 0, 0, 0, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 20, 20, 0, 3, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 250, 250, 0, 254, 0, '0});
    add_row('{1, REG_THRESHOLD, 16'h8000, 0, 0, 0, 0, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 0, 0, 16'h8000, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 0, 255, 16'h8001, 0, 0, '0});
    add_row('{1, REG_CHAN_ORIGIN, 16'h1fff, 0, 0, 0, 0, 0, 0, '0});
    add_row('{1, REG_TICK_ORIGIN, 16'h1fff, 0, 0, 0, 0, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 0, 0, 1, 0, 1,
              '{STAT_OUTSIDE, 8'd0, 17'd0, 8'd0, 8'd0}});
    add_row('{0, REG_THRESHOLD, 0, CMD_LOAD, 13'h1fff, 13'h1fff, 1, 0, 0, '0});
    add_row('{1, REG_SEED_CH_OFS, 16'h1000, 0, 0, 0, 0, 0, 0, '0});
    add_row('{1, REG_SEED_TK_OFS, 16'h0fff, 0, 0, 0, 0, 0, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_GROW, 13'h0fff, 13'h0ffe, 0, 40, 0, '0});
    add_row('{0, REG_THRESHOLD, 0, CMD_CLEAR, 0, 0, 0, 0, 1,
              '{STAT_DONE, 8'd0, 17'd0, 8'd0, 8'd0}});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].ridx, rows[i].val);
      else send_item(rows[i].cmd, rows[i].ch, rows[i].tk, rows[i].sg, rows[i].ix,
                     rows[i].typed, rows[i].res);
    end

    // Random phases: each starts from a new setting and an empty grid.
    for (ph = 0; ph < 7; ph++) begin
      pct = phase_idle[ph];
      case (ph)
        0: v = 0;
        1: v = -32768;
        2: v = 32767;
        default: v = $urandom_range(4000) - 2000;
      endcase
      write_reg(REG_THRESHOLD, 16'(v));
      write_reg(REG_CHAN_ORIGIN, (ph == 1) ? 16'd7936 : (ph == 0) ? 16'd0
                                 : 16'($urandom_range(7936)));
      write_reg(REG_TICK_ORIGIN, (ph == 3) ? 16'd7936 : (ph == 0) ? 16'd0
                                 : 16'($urandom_range(7936)));
      write_reg(REG_SEED_CH_OFS, (ph == 4) ? 16'h1000 : (ph == 5) ? 16'h0fff
                                 : 16'($urandom_range(400) - 200));
      write_reg(REG_SEED_TK_OFS, (ph == 5) ? 16'h1000 : (ph == 4) ? 16'h0fff
                                 : 16'($urandom_range(400) - 200));
      write_reg(REG_REACH_CH, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd15
                              : 16'($urandom_range(6)));
      write_reg(REG_REACH_TK, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd15
                              : 16'($urandom_range(6)));
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0, '0);
      sel = $urandom_range(2);
      wc = (sel == 0) ? 0 : (sel == 1) ? 256 - WIN : $urandom_range(256 - WIN);
      sel = $urandom_range(2);
      wr = (sel == 0) ? 0 : (sel == 1) ? 256 - WIN : $urandom_range(256 - WIN);
      for (i = 0; i < 180; i++) begin
        sender_gap(pct);
        // Quiet stretches inside idling phases.
        if (pct != 0 && (i % 60) < 10) pct = 0;
        else pct = phase_idle[ph];
        sel = $urandom_range(99);
        col = wc + $urandom_range(WIN + 5) - 3;
        row = wr + $urandom_range(WIN + 5) - 3;
        if (sel < 52) begin
          sg = ($urandom_range(9) < 3 || thr >= 32767) ? 16'($urandom)
               : 16'((thr + $urandom_range(1, 200) > 32767) ? 32767
                                                             : thr + $urandom_range(1, 200));
          send_item(CMD_LOAD, 13'(corg + col), 13'(torg + row), sg, 8'($urandom),
                    0, '0);
        end else if (sel < 62) begin
          send_item(CMD_LOAD, 13'($urandom), 13'($urandom), 16'($urandom), 8'($urandom),
                    0, '0);
        end else if (sel < 90) begin
          send_item(CMD_GROW, 13'(corg + sco + col), 13'(torg + sto + row),
                    16'($urandom), 8'($urandom), 0, '0);
        end else if (sel < 96) begin
          send_item(CMD_GROW, 13'($urandom), 13'($urandom), 16'($urandom),
                    8'($urandom), 0, '0);
        end else begin
          send_item(CMD_UNDEF, 13'($urandom), 13'($urandom), 16'($urandom),
                    8'($urandom), 0, '0);
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
